### rtl/sparse_quadratic_gradient_defines.svh
// assertion macros for the sparse quadratic gradient block
// used by the top level; depends on nothing
`ifndef SPARSE_QUADRATIC_GRADIENT_DEFINES_SVH
`define SPARSE_QUADRATIC_GRADIENT_DEFINES_SVH

// condition holds in the same cycle
`define SQG_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define SQG_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sqg_pkg.sv
// shared types, codes and saturating helpers of the sparse quadratic gradient block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sqg_pkg;

	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int MAX_ENTRIES_DEF = 4096;

	// request operation codes
	localparam logic [2:0] OP_BASE    = 3'd0;
	localparam logic [2:0] OP_CURRENT = 3'd1;
	localparam logic [2:0] OP_SOLUTION = 3'd2;
	localparam logic [2:0] OP_SCALE   = 3'd3;
	localparam logic [2:0] OP_ENTRY   = 3'd4;
	localparam logic [2:0] OP_COMPUTE = 3'd5;
	localparam logic [2:0] OP_READ    = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	// register indexes
	localparam logic [2:0] REG_SCALING   = 3'd0;
	localparam logic [2:0] REG_LINEAR    = 3'd1;
	localparam logic [2:0] REG_FULL      = 3'd2;
	localparam logic [2:0] REG_ACTIVE    = 3'd3;
	localparam logic [2:0] REG_DIRECTION = 3'd4;
	localparam logic [2:0] REG_SENSE     = 3'd5;
	localparam logic [2:0] REG_COLUMNS   = 3'd6;
	localparam logic [2:0] REG_ENTRIES   = 3'd7;

	localparam logic [1:0] LIN_CURRENT = 2'd1;
	localparam logic [1:0] LIN_BASE    = 2'd2;

	localparam logic signed [63:0] Q_ONE  = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] Q_HALF = 64'sh0000_0000_8000_0000;

	typedef struct packed {
		logic              scaling_on;
		logic [1:0]        linear_mode;
		logic              full_storage;
		logic              quadratic_active;
		logic signed [63:0] scale_direction;
		logic [1:0]        sense_sign;
		logic [10:0]       column_count;
		logic [12:0]       entry_count;
	} sqg_cfg_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_LIN_RD, S_LIN_LD, S_LIN_M1, S_LIN_M2, S_LIN_WR, S_LIN_END,
		S_UP_RD, S_UP_CHK, S_UP_RA, S_UP_RB, S_UP_LB,
		S_UP_MSD, S_UP_MSS, S_UP_MSE, S_UP_MXX, S_UP_MHX, S_UP_MPX, S_UP_MPE,
		S_UP_MGA, S_UP_GARD, S_UP_GAWR, S_UP_MGB, S_UP_GBRD, S_UP_GBWR,
		S_UP_NEXT, S_UP_END,
		S_FU_RD, S_FU_CHK, S_FU_RB, S_FU_LB, S_FU_MUL, S_FU_RR, S_FU_WR,
		S_FU_NEXT, S_FU_END,
		S_FI_RD, S_FI_LD, S_FI_MUL, S_FI_NEXT, S_FI_HALF,
		S_DONE
	} sqg_state_t;

	// saturating 64-bit signed add
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
		input logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63])
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	// saturating negate
	function automatic logic signed [63:0] sat_neg(input logic signed [63:0] x);
		if (x == 64'sh8000_0000_0000_0000)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		return -x;
	endfunction

endpackage
`default_nettype wire

### rtl/sparse_quadratic_gradient.sv
// Sparse quadratic gradient engine. Loads (costs, solution, scales, matrix entries)
// and reads: a request is accepted when start is high and busy is low, and its
// result appears on data/status with done high for exactly one cycle on the
// following cycle; the receiver cannot stall, so the result must be taken then.
// A compute request keeps busy high while it walks the columns and the stored entries
// through one shared Q32.32 multiplier (four 32x32 passes plus rounding). The linear
// pass takes two products per column for scaled base cost; each entry in use takes
// 4 products when off-diagonal, 4 when diagonal, and 3 more when scaling is on; in
// full storage 1 product per entry plus one per column and a final halving.
// The multiplier sets the compute time. No clearing pass follows reset.
// depends on sqg_pkg, sqg_qmul, sqg_regs and sparse_quadratic_gradient_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_quadratic_gradient_defines.svh"
module sparse_quadratic_gradient #(
	parameter int MAX_COLUMNS = sqg_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ENTRIES = sqg_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         operation,
	input  wire logic [9:0]         column,
	input  wire logic [9:0]         other_column,
	input  wire logic [11:0]        entry_slot,
	input  wire logic signed [63:0] value,
	output logic                    done,
	output logic signed [63:0]      data,
	output logic [1:0]              status,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [5:0]         paddr,
	input  wire logic [63:0]        pwdata,
	output logic [63:0]             prdata,
	output logic                    pready
);

	localparam int CAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNW = $clog2(MAX_COLUMNS + 1);
	localparam int ENW = $clog2(MAX_ENTRIES + 1);

	sqg_pkg::sqg_cfg_t  cfg;
	sqg_pkg::sqg_state_t state_q, state_d;

	// configuration port
	sqg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// shared multiplier
	logic               mul_start, mul_done, mul_pend_q;
	logic signed [63:0] mul_a, mul_b, mul_res;

	sqg_qmul u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	// clamped counts and decoded settings
	logic [CNW-1:0] nc;
	logic [ENW-1:0] ne;
	logic           sc, accept, reject, go;

	assign nc = (32'(cfg.column_count) < MAX_COLUMNS) ? CNW'(cfg.column_count)
		: CNW'(MAX_COLUMNS);
	assign ne = (32'(cfg.entry_count) < MAX_ENTRIES) ? ENW'(cfg.entry_count)
		: ENW'(MAX_ENTRIES);
	assign sc     = cfg.scaling_on;
	assign busy   = (state_q != sqg_pkg::S_IDLE);
	assign accept = start && !busy;
	assign reject = sc && cfg.full_storage;
	assign go     = accept && (operation == sqg_pkg::OP_COMPUTE) && !reject;

	// request indexes
	logic [31:0]    col_ext, slot_ext;
	logic [CAW-1:0] col_idx;
	logic [EAW-1:0] slot_idx;
	logic           col_bad, slot_bad, read_bad;

	assign col_ext  = 32'(column);
	assign slot_ext = 32'(entry_slot);
	assign col_idx  = col_ext[CAW-1:0];
	assign slot_idx = slot_ext[EAW-1:0];
	assign col_bad  = (col_ext >= MAX_COLUMNS);
	assign slot_bad = (slot_ext >= MAX_ENTRIES);
	assign read_bad = (col_ext >= 32'(nc));

	// walk counters and latched operands
	logic [CNW-1:0]     i_q, i_nx;
	logic [ENW-1:0]     k_q, k_nx;
	logic [9:0]         a_q, b_q;
	logic signed [63:0] e_q, xa_q, xb_q, sa_q, sb_q, t_q, p_q, g_q, off_q;
	logic signed [63:0] base_q, cur_q, scl_q, r_q;
	logic [31:0]        a_ext, b_ext;
	logic [CAW-1:0]     a_idx, b_idx;
	logic [CAW-1:0]     i_idx;
	logic [EAW-1:0]     k_idx;
	logic               i_last, k_last;

	assign i_nx   = i_q + CNW'(1);
	assign k_nx   = k_q + ENW'(1);
	assign i_last = (i_nx == nc);
	assign k_last = (k_nx == ne);
	assign a_ext  = 32'(a_q);
	assign b_ext  = 32'(b_q);
	assign a_idx  = a_ext[CAW-1:0];
	assign b_idx  = b_ext[CAW-1:0];
	assign i_idx  = i_q[CAW-1:0];
	assign k_idx  = 32'(k_q) < MAX_ENTRIES ? k_q[EAW-1:0] : EAW'(0);

	// memories
	logic signed [63:0] base_mem [MAX_COLUMNS];
	logic signed [63:0] cur_mem  [MAX_COLUMNS];
	logic signed [63:0] sol_mem  [MAX_COLUMNS];
	logic signed [63:0] scl_mem  [MAX_COLUMNS];
	logic signed [63:0] grad_mem [MAX_COLUMNS];
	logic signed [63:0] row_mem  [MAX_COLUMNS];
	logic [9:0]         ea_mem   [MAX_ENTRIES];
	logic [9:0]         eb_mem   [MAX_ENTRIES];
	logic signed [63:0] ev_mem   [MAX_ENTRIES];

	logic signed [63:0] base_rd_q, cur_rd_q, sol_rd_q, scl_rd_q, grad_rd_q, row_rd_q;
	logic [9:0]         ea_rd_q, eb_rd_q;
	logic signed [63:0] ev_rd_q;

	logic [CAW-1:0]     cadr, gadr, radr, gwa, rwa;
	logic               gwe, rwe;
	logic signed [63:0] gwd, rwd, lin;
	logic               is_mul;
	logic               ld_ok, ent_ok;

	assign ld_ok  = accept && !col_bad;
	assign ent_ok = accept && (operation == sqg_pkg::OP_ENTRY) && !slot_bad;

	// per-column tables
	always_ff @(posedge clk) begin
		if (ld_ok && operation == sqg_pkg::OP_BASE)
			base_mem[col_idx] <= value;
		if (ld_ok && operation == sqg_pkg::OP_CURRENT)
			cur_mem[col_idx] <= value;
		if (ld_ok && operation == sqg_pkg::OP_SOLUTION)
			sol_mem[col_idx] <= value;
		if (ld_ok && operation == sqg_pkg::OP_SCALE)
			scl_mem[col_idx] <= value;
		base_rd_q <= base_mem[cadr];
		cur_rd_q  <= cur_mem[cadr];
		sol_rd_q  <= sol_mem[cadr];
		scl_rd_q  <= scl_mem[cadr];
	end

	// gradient and row sum stores
	always_ff @(posedge clk) begin
		if (gwe)
			grad_mem[gwa] <= gwd;
		grad_rd_q <= grad_mem[gadr];
	end

	always_ff @(posedge clk) begin
		if (rwe)
			row_mem[rwa] <= rwd;
		row_rd_q <= row_mem[radr];
	end

	// matrix entry store
	always_ff @(posedge clk) begin
		if (ent_ok) begin
			ea_mem[slot_idx] <= column;
			eb_mem[slot_idx] <= other_column;
			ev_mem[slot_idx] <= value;
		end
		ea_rd_q <= ea_mem[k_idx];
		eb_rd_q <= eb_mem[k_idx];
		ev_rd_q <= ev_mem[k_idx];
	end

	// entry columns within the columns in use
	logic ent_in;
	assign ent_in = (32'(ea_rd_q) < 32'(nc)) && (32'(eb_rd_q) < 32'(nc));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sqg_pkg::S_IDLE:
				if (go)
					state_d = (nc != CNW'(0)) ? sqg_pkg::S_LIN_RD : sqg_pkg::S_LIN_END;
			sqg_pkg::S_LIN_RD: state_d = sqg_pkg::S_LIN_LD;
			sqg_pkg::S_LIN_LD:
				state_d = (cfg.quadratic_active && cfg.linear_mode == sqg_pkg::LIN_BASE
					&& sc) ? sqg_pkg::S_LIN_M1 : sqg_pkg::S_LIN_WR;
			sqg_pkg::S_LIN_M1: if (mul_done) state_d = sqg_pkg::S_LIN_M2;
			sqg_pkg::S_LIN_M2: if (mul_done) state_d = sqg_pkg::S_LIN_WR;
			sqg_pkg::S_LIN_WR: state_d = i_last ? sqg_pkg::S_LIN_END : sqg_pkg::S_LIN_RD;
			sqg_pkg::S_LIN_END: begin
				priority if (!cfg.quadratic_active)
					state_d = sqg_pkg::S_DONE;
				else if (!cfg.full_storage)
					state_d = (ne != ENW'(0)) ? sqg_pkg::S_UP_RD : sqg_pkg::S_UP_END;
				else
					state_d = (ne != ENW'(0)) ? sqg_pkg::S_FU_RD : sqg_pkg::S_FU_END;
			end
			sqg_pkg::S_UP_RD:  state_d = sqg_pkg::S_UP_CHK;
			sqg_pkg::S_UP_CHK: state_d = ent_in ? sqg_pkg::S_UP_RA : sqg_pkg::S_UP_NEXT;
			sqg_pkg::S_UP_RA:  state_d = sqg_pkg::S_UP_RB;
			sqg_pkg::S_UP_RB:  state_d = sqg_pkg::S_UP_LB;
			sqg_pkg::S_UP_LB:
				state_d = sc ? sqg_pkg::S_UP_MSD
					: ((a_q == b_q) ? sqg_pkg::S_UP_MHX : sqg_pkg::S_UP_MXX);
			sqg_pkg::S_UP_MSD: if (mul_done) state_d = sqg_pkg::S_UP_MSS;
			sqg_pkg::S_UP_MSS: if (mul_done) state_d = sqg_pkg::S_UP_MSE;
			sqg_pkg::S_UP_MSE:
				if (mul_done)
					state_d = (a_q == b_q) ? sqg_pkg::S_UP_MHX : sqg_pkg::S_UP_MXX;
			sqg_pkg::S_UP_MXX: if (mul_done) state_d = sqg_pkg::S_UP_MPE;
			sqg_pkg::S_UP_MHX: if (mul_done) state_d = sqg_pkg::S_UP_MPX;
			sqg_pkg::S_UP_MPX: if (mul_done) state_d = sqg_pkg::S_UP_MPE;
			sqg_pkg::S_UP_MPE: if (mul_done) state_d = sqg_pkg::S_UP_MGA;
			sqg_pkg::S_UP_MGA: if (mul_done) state_d = sqg_pkg::S_UP_GARD;
			sqg_pkg::S_UP_GARD: state_d = sqg_pkg::S_UP_GAWR;
			sqg_pkg::S_UP_GAWR:
				state_d = (a_q == b_q) ? sqg_pkg::S_UP_NEXT : sqg_pkg::S_UP_MGB;
			sqg_pkg::S_UP_MGB: if (mul_done) state_d = sqg_pkg::S_UP_GBRD;
			sqg_pkg::S_UP_GBRD: state_d = sqg_pkg::S_UP_GBWR;
			sqg_pkg::S_UP_GBWR: state_d = sqg_pkg::S_UP_NEXT;
			sqg_pkg::S_UP_NEXT: state_d = k_last ? sqg_pkg::S_UP_END : sqg_pkg::S_UP_RD;
			sqg_pkg::S_UP_END:  state_d = sqg_pkg::S_DONE;
			sqg_pkg::S_FU_RD:  state_d = sqg_pkg::S_FU_CHK;
			sqg_pkg::S_FU_CHK: state_d = ent_in ? sqg_pkg::S_FU_RB : sqg_pkg::S_FU_NEXT;
			sqg_pkg::S_FU_RB:  state_d = sqg_pkg::S_FU_LB;
			sqg_pkg::S_FU_LB:  state_d = sqg_pkg::S_FU_MUL;
			sqg_pkg::S_FU_MUL: if (mul_done) state_d = sqg_pkg::S_FU_RR;
			sqg_pkg::S_FU_RR:  state_d = sqg_pkg::S_FU_WR;
			sqg_pkg::S_FU_WR:  state_d = sqg_pkg::S_FU_NEXT;
			sqg_pkg::S_FU_NEXT: state_d = k_last ? sqg_pkg::S_FU_END : sqg_pkg::S_FU_RD;
			sqg_pkg::S_FU_END:
				state_d = (nc != CNW'(0)) ? sqg_pkg::S_FI_RD : sqg_pkg::S_FI_HALF;
			sqg_pkg::S_FI_RD:  state_d = sqg_pkg::S_FI_LD;
			sqg_pkg::S_FI_LD:  state_d = sqg_pkg::S_FI_MUL;
			sqg_pkg::S_FI_MUL: if (mul_done) state_d = sqg_pkg::S_FI_NEXT;
			sqg_pkg::S_FI_NEXT: state_d = i_last ? sqg_pkg::S_FI_HALF : sqg_pkg::S_FI_RD;
			sqg_pkg::S_FI_HALF: if (mul_done) state_d = sqg_pkg::S_DONE;
			sqg_pkg::S_DONE:   state_d = sqg_pkg::S_IDLE;
			default:           state_d = sqg_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sqg_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// linear part of one column
	always_comb begin
		priority if (!cfg.quadratic_active)
			lin = base_q;
		else if (cfg.linear_mode == sqg_pkg::LIN_CURRENT)
			lin = cur_q;
		else if (cfg.linear_mode == sqg_pkg::LIN_BASE)
			lin = sc ? t_q : base_q;
		else
			lin = 64'sd0;
	end

	// datapath controls per state
	always_comb begin
		is_mul = 1'b0;
		mul_a  = xb_q;
		mul_b  = e_q;
		cadr   = i_idx;
		gadr   = col_idx;
		radr   = i_idx;
		gwe    = 1'b0;
		gwa    = i_idx;
		gwd    = lin;
		rwe    = 1'b0;
		rwa    = i_idx;
		rwd    = 64'sd0;
		unique case (state_q)
			sqg_pkg::S_LIN_M1: begin
				is_mul = 1'b1;
				mul_a  = base_q;
				mul_b  = cfg.scale_direction;
			end
			sqg_pkg::S_LIN_M2: begin
				is_mul = 1'b1;
				mul_a  = t_q;
				mul_b  = scl_q;
			end
			sqg_pkg::S_LIN_WR: begin
				gwe = 1'b1;
				rwe = 1'b1;
			end
			sqg_pkg::S_UP_RA: cadr = a_idx;
			sqg_pkg::S_UP_RB, sqg_pkg::S_FU_RB: cadr = b_idx;
			sqg_pkg::S_UP_MSD: begin
				is_mul = 1'b1;
				mul_a  = sa_q;
				mul_b  = cfg.scale_direction;
			end
			sqg_pkg::S_UP_MSS: begin
				is_mul = 1'b1;
				mul_a  = t_q;
				mul_b  = sb_q;
			end
			sqg_pkg::S_UP_MSE: begin
				is_mul = 1'b1;
				mul_a  = e_q;
				mul_b  = t_q;
			end
			sqg_pkg::S_UP_MXX: begin
				is_mul = 1'b1;
				mul_a  = xa_q;
				mul_b  = xb_q;
			end
			sqg_pkg::S_UP_MHX: begin
				is_mul = 1'b1;
				mul_a  = sqg_pkg::Q_HALF;
				mul_b  = xa_q;
			end
			sqg_pkg::S_UP_MPX: begin
				is_mul = 1'b1;
				mul_a  = p_q;
				mul_b  = xa_q;
			end
			sqg_pkg::S_UP_MPE: begin
				is_mul = 1'b1;
				mul_a  = p_q;
				mul_b  = e_q;
			end
			sqg_pkg::S_UP_MGA, sqg_pkg::S_FU_MUL: is_mul = 1'b1;
			sqg_pkg::S_UP_GARD: gadr = a_idx;
			sqg_pkg::S_UP_GAWR: begin
				gwe = 1'b1;
				gwa = a_idx;
				gwd = sqg_pkg::sat_add(grad_rd_q, g_q);
			end
			sqg_pkg::S_UP_MGB: begin
				is_mul = 1'b1;
				mul_a  = xa_q;
			end
			sqg_pkg::S_UP_GBRD: gadr = b_idx;
			sqg_pkg::S_UP_GBWR: begin
				gwe = 1'b1;
				gwa = b_idx;
				gwd = sqg_pkg::sat_add(grad_rd_q, g_q);
			end
			sqg_pkg::S_FU_RR: radr = a_idx;
			sqg_pkg::S_FU_WR: begin
				rwe = 1'b1;
				rwa = a_idx;
				rwd = sqg_pkg::sat_add(row_rd_q, p_q);
			end
			sqg_pkg::S_FI_RD: gadr = i_idx;
			sqg_pkg::S_FI_LD: begin
				gwe = 1'b1;
				gwd = sqg_pkg::sat_add(grad_rd_q, row_rd_q);
			end
			sqg_pkg::S_FI_MUL: begin
				is_mul = 1'b1;
				mul_a  = r_q;
				mul_b  = xa_q;
			end
			sqg_pkg::S_FI_HALF: begin
				is_mul = 1'b1;
				mul_a  = off_q;
				mul_b  = sqg_pkg::Q_HALF;
			end
			default: ;
		endcase
	end

	assign mul_start = is_mul && !mul_pend_q;

	// multiplier handshake and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_pend_q <= 1'b0;
			i_q        <= '0;
			k_q        <= '0;
		end else begin
			if (mul_start)
				mul_pend_q <= 1'b1;
			else if (mul_done)
				mul_pend_q <= 1'b0;
			priority case (state_q)
				sqg_pkg::S_IDLE: begin
					i_q <= '0;
					k_q <= '0;
				end
				sqg_pkg::S_LIN_WR, sqg_pkg::S_FI_NEXT: i_q <= i_nx;
				sqg_pkg::S_LIN_END: k_q <= '0;
				sqg_pkg::S_UP_NEXT, sqg_pkg::S_FU_NEXT: k_q <= k_nx;
				sqg_pkg::S_FU_END: i_q <= '0;
				default: ;
			endcase
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		unique case (state_q)
			sqg_pkg::S_IDLE: off_q <= 64'sd0;
			sqg_pkg::S_LIN_LD: begin
				base_q <= base_rd_q;
				cur_q  <= cur_rd_q;
				scl_q  <= scl_rd_q;
			end
			sqg_pkg::S_UP_CHK, sqg_pkg::S_FU_CHK: begin
				a_q <= ea_rd_q;
				b_q <= eb_rd_q;
				e_q <= ev_rd_q;
			end
			sqg_pkg::S_UP_RB: begin
				sa_q <= scl_rd_q;
				xa_q <= sol_rd_q;
			end
			sqg_pkg::S_UP_LB: begin
				sb_q <= scl_rd_q;
				xb_q <= sol_rd_q;
			end
			sqg_pkg::S_FU_LB: xb_q <= sol_rd_q;
			sqg_pkg::S_FI_LD: begin
				r_q  <= row_rd_q;
				xa_q <= sol_rd_q;
			end
			sqg_pkg::S_LIN_M1, sqg_pkg::S_LIN_M2, sqg_pkg::S_UP_MSD, sqg_pkg::S_UP_MSS:
				if (mul_done) t_q <= mul_res;
			sqg_pkg::S_UP_MSE: if (mul_done) e_q <= mul_res;
			sqg_pkg::S_UP_MXX, sqg_pkg::S_UP_MHX, sqg_pkg::S_UP_MPX, sqg_pkg::S_FU_MUL:
				if (mul_done) p_q <= mul_res;
			sqg_pkg::S_UP_MPE, sqg_pkg::S_FI_MUL:
				if (mul_done) off_q <= sqg_pkg::sat_add(off_q, mul_res);
			sqg_pkg::S_UP_MGA, sqg_pkg::S_UP_MGB: if (mul_done) g_q <= mul_res;
			sqg_pkg::S_FI_HALF: if (mul_done) off_q <= mul_res;
			sqg_pkg::S_UP_END:
				if (sc) begin
					priority if (cfg.sense_sign[1])
						off_q <= sqg_pkg::sat_neg(off_q);
					else if (cfg.sense_sign == 2'b00)
						off_q <= 64'sd0;
				end
			default: ;
		endcase
	end

	// result strobe and status
	logic               done_q, rdsel_q;
	logic [1:0]         status_q;
	logic signed [63:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			rdsel_q  <= 1'b0;
			status_q <= sqg_pkg::ST_OK;
			data_q   <= 64'sd0;
		end else begin
			done_q   <= 1'b0;
			rdsel_q  <= 1'b0;
			status_q <= sqg_pkg::ST_OK;
			data_q   <= 64'sd0;
			if (state_q == sqg_pkg::S_DONE) begin
				done_q <= 1'b1;
				data_q <= off_q;
			end else if (accept) begin
				priority case (operation)
					sqg_pkg::OP_BASE, sqg_pkg::OP_CURRENT,
					sqg_pkg::OP_SOLUTION, sqg_pkg::OP_SCALE: begin
						done_q   <= 1'b1;
						status_q <= col_bad ? sqg_pkg::ST_RANGE : sqg_pkg::ST_OK;
					end
					sqg_pkg::OP_ENTRY: begin
						done_q   <= 1'b1;
						status_q <= slot_bad ? sqg_pkg::ST_RANGE : sqg_pkg::ST_OK;
					end
					sqg_pkg::OP_COMPUTE:
						if (reject) begin
							done_q   <= 1'b1;
							status_q <= sqg_pkg::ST_REJECT;
						end
					sqg_pkg::OP_READ: begin
						done_q   <= 1'b1;
						rdsel_q  <= !read_bad;
						status_q <= read_bad ? sqg_pkg::ST_RANGE : sqg_pkg::ST_OK;
					end
					default: done_q <= 1'b1;
				endcase
			end
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign data   = rdsel_q ? grad_rd_q : data_q;

	// checks
	`SQG_ASSERT_NOW(a_no_result_busy, clk, arst_n, busy, !done, "result while busy")
	`SQG_ASSERT_NEXT(a_short_request, clk, arst_n,
		start && !busy && operation != sqg_pkg::OP_COMPUTE, done, "request without result")
	`SQG_ASSERT_NEXT(a_compute_ends, clk, arst_n, state_q == sqg_pkg::S_DONE, done && !busy,
		"compute end without result")
	`SQG_ASSERT_NOW(a_mul_owned, clk, arst_n, mul_done, mul_pend_q, "stray product")

endmodule
`default_nettype wire

### rtl/sqg_qmul.sv
// shared Q32.32 multiplier: four 32x32 partial products, rounding and saturation
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module sqg_qmul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic                    done,
	output logic signed [63:0]      result
);

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [2:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [127:0] prodsh_q, acc_q;
	logic signed [63:0] res_q;

	logic [63:0]  ua_in, ub_in;
	logic [31:0]  pa, pb;
	logic [63:0]  prod;
	logic [127:0] prod_sh;
	logic [63:0]  limit, mag_raw, mag;
	logic         over;

	// magnitudes of the operands
	assign ua_in = a[63] ? 64'(64'd0 - a) : a;
	assign ub_in = b[63] ? 64'(64'd0 - b) : b;

	// partial product for the current pass
	assign pa   = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign pb   = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign prod = pa * pb;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: prod_sh = {64'd0, prod};
			2'd1, 2'd2: prod_sh = {32'd0, prod, 32'd0};
			default: prod_sh = {prod, 64'd0};
		endcase
	end

	// rounding already added; saturate and restore sign
	assign limit   = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	assign mag_raw = acc_q[95:32];
	assign over    = (|acc_q[127:96]) || (mag_raw > limit);
	assign mag     = over ? limit : mag_raw;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 3'd5);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5)
					run_q <= 1'b0;
			end
		end
	end

	// accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			ua_q     <= ua_in;
			ub_q     <= ub_in;
			neg_q    <= a[63] ^ b[63];
			acc_q    <= 128'd0;
			prodsh_q <= 128'd0;
		end else if (run_q) begin
			if (cnt_q < 3'd4) begin
				prodsh_q <= prod_sh;
				acc_q    <= acc_q + prodsh_q;
			end else if (cnt_q == 3'd4) begin
				acc_q <= acc_q + prodsh_q + 128'h8000_0000;
			end else begin
				res_q <= neg_q ? 64'(64'd0 - mag) : mag;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

### rtl/sqg_regs.sv
// configuration registers behind the APB-style port
// depends on sqg_pkg
`timescale 1ns / 1ps
`default_nettype none
module sqg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	output sqg_pkg::sqg_cfg_t cfg
);

	sqg_pkg::sqg_cfg_t cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[5:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scaling_on       <= 1'b0;
			cfg_q.linear_mode      <= 2'd0;
			cfg_q.full_storage     <= 1'b0;
			cfg_q.quadratic_active <= 1'b1;
			cfg_q.scale_direction  <= sqg_pkg::Q_ONE;
			cfg_q.sense_sign       <= 2'b01;
			cfg_q.column_count     <= 11'd1;
			cfg_q.entry_count      <= 13'd0;
		end else if (wr) begin
			unique case (idx)
				sqg_pkg::REG_SCALING:   cfg_q.scaling_on       <= pwdata[0];
				sqg_pkg::REG_LINEAR:    cfg_q.linear_mode      <= pwdata[1:0];
				sqg_pkg::REG_FULL:      cfg_q.full_storage     <= pwdata[0];
				sqg_pkg::REG_ACTIVE:    cfg_q.quadratic_active <= pwdata[0];
				sqg_pkg::REG_DIRECTION: cfg_q.scale_direction  <= pwdata;
				sqg_pkg::REG_SENSE:     cfg_q.sense_sign       <= pwdata[1:0];
				sqg_pkg::REG_COLUMNS:   cfg_q.column_count     <= pwdata[10:0];
				sqg_pkg::REG_ENTRIES:   cfg_q.entry_count      <= pwdata[12:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			sqg_pkg::REG_SCALING:   prdata = 64'(cfg_q.scaling_on);
			sqg_pkg::REG_LINEAR:    prdata = 64'(cfg_q.linear_mode);
			sqg_pkg::REG_FULL:      prdata = 64'(cfg_q.full_storage);
			sqg_pkg::REG_ACTIVE:    prdata = 64'(cfg_q.quadratic_active);
			sqg_pkg::REG_DIRECTION: prdata = cfg_q.scale_direction;
			sqg_pkg::REG_SENSE:     prdata = 64'(cfg_q.sense_sign);
			sqg_pkg::REG_COLUMNS:   prdata = 64'(cfg_q.column_count);
			sqg_pkg::REG_ENTRIES:   prdata = 64'(cfg_q.entry_count);
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire
